>>> design/number_to_ascii_formatter_macros.svh
// ----------------------------------------------------------------------------
// number_to_ascii_formatter assertion macros
// Clocked property shorthands used by the formatter's datapath.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_MACROS_SVH
`define NUMBER_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication, quiet while in reset
`define NTAF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define NTAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ntaf_pkg.sv
// ----------------------------------------------------------------------------
// ntaf_pkg
// Shared constants, command/status types and glyph helper of the formatter.
// ----------------------------------------------------------------------------
package ntaf_pkg;

  // default parameter values
  localparam int NTAF_CHARS_PER_ROW = 16;
  localparam int NTAF_MAX_DIGITS    = 32;

  // display_lines register
  localparam logic [3:0] NTAF_DISPLAY_LINES_RESET = 4'd4;
  localparam logic [3:0] NTAF_DISPLAY_LINES_MAX   = 4'd8;

  // divider widths
  localparam int DIV_DVD_W = 8;
  localparam int DIV_DVS_W = 7;

  // format codes
  localparam logic [2:0] FUNC_UDEC  = 3'd0;
  localparam logic [2:0] FUNC_BLANK = 3'd1;
  localparam logic [2:0] FUNC_SDEC  = 3'd2;
  localparam logic [2:0] FUNC_HEX   = 3'd3;
  localparam logic [2:0] FUNC_BIN   = 3'd4;

  // characters
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_SPACE = 7'h20;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic line_capture;
    logic len_load;
    logic emit;
  } ntaf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic div_busy;
    logic out_free;
    logic last_char;
  } ntaf_sts_t;

  // digit value to uppercase hex character
  function automatic logic [6:0] digit_glyph(input logic [3:0] d);
    logic [6:0] g;
    if (d < 4'd10) begin
      g = CH_ZERO + 7'(d);
    end else begin
      g = CH_A + 7'(d - 4'd10);
    end
    return g;
  endfunction

endpackage

>>> design/ntaf_divu.sv
// ----------------------------------------------------------------------------
// ntaf_divu
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntaf_divu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ntaf_pkg::DIV_DVD_W-1:0]  dividend,
  input  logic [ntaf_pkg::DIV_DVS_W-1:0]  divisor,
  output logic                            busy,
  output logic [ntaf_pkg::DIV_DVS_W-1:0]  remainder
);
  import ntaf_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W + 1);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_DVS_W:0]   trial;

  assign busy      = (cnt_r != '0);
  assign remainder = rem_r;

  // one trial subtraction a cycle; quotient bits shift into the dividend
  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    trial   = {rem_r, dvd_r[DIV_DVD_W-1]};
    if (start) begin
      cnt_nxt = CNT_W'(DIV_DVD_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_DVS_W'(trial - {1'b0, dvs_r});
        dvd_nxt = {dvd_r[DIV_DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIV_DVS_W'(trial);
        dvd_nxt = {dvd_r[DIV_DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

>>> design/ntaf_datapath.sv
// ----------------------------------------------------------------------------
// ntaf_datapath
// Operand capture, BCD conversion, position wrapping and character output.
// ----------------------------------------------------------------------------
`include "number_to_ascii_formatter_macros.svh"

module ntaf_datapath #(
  parameter int CHARS_PER_ROW = ntaf_pkg::NTAF_CHARS_PER_ROW,
  parameter int MAX_DIGITS    = ntaf_pkg::NTAF_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ntaf_pkg::ntaf_cmd_t cmd_i,
  output ntaf_pkg::ntaf_sts_t sts_o,
  input  logic [2:0]          in_func,
  input  logic [31:0]         in_number,
  input  logic [5:0]          in_length,
  input  logic [2:0]          in_start_line,
  input  logic [6:0]          in_start_column,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          out_glyph_code,
  output logic [2:0]          out_text_line,
  output logic [5:0]          out_text_column,
  output logic                out_last,
  input  logic                cfg_valid,
  input  logic [3:0]          cfg_data
);
  import ntaf_pkg::*;

  localparam int PW        = $clog2(MAX_DIGITS);
  localparam int LEN_W     = $clog2(MAX_DIGITS + 1);
  localparam int COL_W     = $clog2(CHARS_PER_ROW);
  localparam int COL_RECIP = (65536 + CHARS_PER_ROW - 1) / CHARS_PER_ROW;

  // configuration
  logic [3:0] dl_r;
  logic [3:0] dl_eff;

  // captured operand
  logic [31:0]      mag_r;
  logic             is_hex_r, is_bin_r;
  logic             blank_r, blank_nxt;
  logic             sign_pend_r, sign_pend_nxt;
  logic [6:0]       sign_char_r;
  logic [LEN_W-1:0] len_in_r;

  // double dabble
  logic [31:0] bin_sh_r, bin_sh_nxt;
  logic [39:0] bcd_r, bcd_nxt;

  // emission
  logic [PW-1:0]    p_r, p_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [2:0]       line_r, line_nxt;

  // output register
  logic       out_valid_r;
  logic [6:0] out_glyph_r;
  logic [2:0] out_line_r;
  logic [5:0] out_col_r;
  logic       out_last_r;

  // input decode
  logic             in_neg, in_zero, in_bz, in_sz;
  logic [LEN_W-1:0] len_sat, len_bz;
  logic [7:0]       pos0;
  logic [23:0]      pos_prod;
  logic [7:0]       pos_q, pos_rem;
  logic [31:0]      mag_in;

  // divider
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DVS_W-1:0] div_divisor;
  logic                 div_busy;
  logic [DIV_DVS_W-1:0] div_rem;

  // digit view
  logic [3:0]       dec_dig [10];
  logic [3:0]       hex_nib [8];
  logic [3:0]       cur_dig;
  logic [6:0]       cur_glyph;
  logic [LEN_W-1:0] auto_len, len_eff;
  logic             last_char, out_free;

  // display_lines register, zero acts as one and large values as eight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= NTAF_DISPLAY_LINES_RESET;
    end else if (cfg_valid) begin
      dl_r <= cfg_data;
    end
  end

  assign dl_eff = (dl_r == 4'd0) ? 4'd1 :
                  (dl_r > NTAF_DISPLAY_LINES_MAX) ? NTAF_DISPLAY_LINES_MAX : dl_r;

  // input decode: blank-zero and signed-zero shift the first position
  always_comb begin
    in_zero = (in_number == 32'd0);
    in_neg  = (in_func == FUNC_SDEC) && in_number[31];
    in_bz   = (in_func == FUNC_BLANK) && in_zero;
    in_sz   = (in_func == FUNC_SDEC) && in_zero;
    len_sat = (in_length > 6'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : LEN_W'(in_length);
    len_bz  = (len_sat == '0) ? LEN_W'(1) : len_sat;
    mag_in  = in_neg ? (32'd0 - in_number) : in_number;
    pos0    = 8'(in_start_column) + (in_sz ? 8'd1 : 8'd0)
              + (in_bz ? (8'(len_bz) - 8'd1) : 8'd0);
    // column split by reciprocal multiply, exact over an 8-bit position
    pos_prod = 24'(pos0) * 24'(COL_RECIP);
    pos_q    = pos_prod[23:16];
    pos_rem  = pos0 - 8'(pos_q * 8'(CHARS_PER_ROW));
  end

  assign sts_o.has_result = (in_func <= FUNC_BIN) &&
                            !((in_func == FUNC_BIN) && (in_length == 6'd0));

  // line wrap: start line plus column carry, modulo the line count
  assign div_start    = cmd_i.load;
  assign div_dividend = DIV_DVD_W'(8'(in_start_line) + pos_q);
  assign div_divisor  = DIV_DVS_W'(dl_eff);

  ntaf_divu u_divu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // four double-dabble bit steps per conversion cycle
  always_comb begin
    bcd_nxt    = bcd_r;
    bin_sh_nxt = bin_sh_r;
    if (cmd_i.load) begin
      bcd_nxt    = '0;
      bin_sh_nxt = mag_in;
    end else if (cmd_i.conv_step) begin
      for (int k = 0; k < 4; k++) begin
        for (int d = 0; d < 10; d++) begin
          if (bcd_nxt[d*4 +: 4] >= 4'd5) begin
            bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
          end
        end
        bcd_nxt    = {bcd_nxt[38:0], bin_sh_nxt[31]};
        bin_sh_nxt = {bin_sh_nxt[30:0], 1'b0};
      end
    end
  end

  // digit arrays
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      dec_dig[i] = bcd_r[i*4 +: 4];
    end
    for (int i = 0; i < 8; i++) begin
      hex_nib[i] = mag_r[i*4 +: 4];
    end
  end

  // automatic length: highest non-zero digit
  always_comb begin
    auto_len = LEN_W'(1);
    if (is_hex_r) begin
      for (int i = 0; i < 8; i++) begin
        if (hex_nib[i] != 4'd0) auto_len = LEN_W'(i + 1);
      end
    end else begin
      for (int i = 0; i < 10; i++) begin
        if (dec_dig[i] != 4'd0) auto_len = LEN_W'(i + 1);
      end
    end
    len_eff = (len_in_r == '0) ? auto_len : len_in_r;
  end

  // current digit; positions past the 32-bit range read as zero
  always_comb begin
    if (is_bin_r) begin
      cur_dig = {3'b000, mag_r[5'(p_r)]};
    end else if (is_hex_r) begin
      cur_dig = (p_r < 8) ? hex_nib[p_r[2:0]] : 4'd0;
    end else begin
      cur_dig = (p_r < 10) ? dec_dig[p_r[3:0]] : 4'd0;
    end
  end

  // character choice
  always_comb begin
    if (sign_pend_r) begin
      cur_glyph = sign_char_r;
    end else if (blank_r && (cur_dig == 4'd0)) begin
      cur_glyph = CH_SPACE;
    end else begin
      cur_glyph = digit_glyph(cur_dig);
    end
  end

  assign last_char = !sign_pend_r && (p_r == '0);
  assign out_free  = !out_valid_r || !out_stall;

  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = out_free;
  assign sts_o.last_char = last_char;

  // emission state: digit counter, blanking, sign, wrapped position
  always_comb begin
    p_nxt         = p_r;
    blank_nxt     = blank_r;
    sign_pend_nxt = sign_pend_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    if (cmd_i.load) begin
      blank_nxt     = (in_func == FUNC_BLANK) && !in_zero;
      sign_pend_nxt = (in_func == FUNC_SDEC) && !in_zero;
      col_nxt       = COL_W'(pos_rem);
    end
    if (cmd_i.line_capture) begin
      line_nxt = div_rem[2:0];
    end
    if (cmd_i.len_load) begin
      p_nxt = PW'(len_eff - 1'b1);
    end
    if (cmd_i.emit) begin
      if (sign_pend_r) begin
        sign_pend_nxt = 1'b0;
      end else begin
        p_nxt = p_r - 1'b1;
        if (cur_dig != 4'd0) blank_nxt = 1'b0;
      end
      if (col_r == COL_W'(CHARS_PER_ROW - 1)) begin
        col_nxt  = '0;
        line_nxt = ((4'(line_r) + 4'd1) == dl_eff) ? 3'd0 : (line_r + 3'd1);
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // operand and emission registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mag_r        <= mag_in;
      is_hex_r     <= (in_func == FUNC_HEX);
      is_bin_r     <= (in_func == FUNC_BIN);
      sign_char_r  <= in_number[31] ? CH_MINUS : CH_PLUS;
      len_in_r     <= in_bz ? LEN_W'(1) : len_sat;
    end
    bcd_r       <= bcd_nxt;
    bin_sh_r    <= bin_sh_nxt;
    p_r         <= p_nxt;
    blank_r     <= blank_nxt;
    sign_pend_r <= sign_pend_nxt;
    col_r       <= col_nxt;
    line_r      <= line_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_glyph_r <= cur_glyph;
      out_line_r  <= line_r;
      out_col_r   <= 6'(col_r);
      out_last_r  <= last_char;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_code  = out_glyph_r;
  assign out_text_line   = out_line_r;
  assign out_text_column = out_col_r;
  assign out_last        = out_last_r;

  // checks
  `NTAF_ASSERT_SAME(a_emit_room, cmd_i.emit, out_free, "beat loaded over a held result")
  `NTAF_ASSERT_SAME(a_pos_range, cmd_i.emit,
                    (col_r < CHARS_PER_ROW) && (4'(line_r) < dl_eff), "position out of range")
  `NTAF_ASSERT_NEXT(a_last_beat, cmd_i.emit && last_char, out_valid_r && out_last_r, "final beat not flagged")
  `NTAF_ASSERT_SAME(a_div_idle, cmd_i.line_capture, !div_busy, "divider read while busy")

endmodule

>>> design/ntaf_ctrl.sv
// ----------------------------------------------------------------------------
// ntaf_ctrl
// Sequencer: conversion with line wrap, length, then one beat a cycle while the output is free.
// ----------------------------------------------------------------------------
module ntaf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ntaf_pkg::ntaf_sts_t sts_i,
  output ntaf_pkg::ntaf_cmd_t cmd_o
);
  import ntaf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && sts_i.has_result) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        if (sts_i.div_busy) begin
          cmd_o.conv_step = 1'b1;
        end else begin
          cmd_o.line_capture = 1'b1;
          state_nxt          = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.len_load = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_char) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats a 32-bit number as ASCII characters with wrapped text positions.
// ----------------------------------------------------------------------------
// A number yields 1 to 33 characters, one a cycle while the output is not stalled;
// no new number is taken until the last character is issued, and a number that
// yields no characters is taken while idle and produces no beat.
// The wait before the first character is set by the eight-step line-wrap division; BCD conversion runs alongside.
// Reset: rst_n synchronous, active low; clears the sequencer and output
// valid, and sets display_lines to 4.
module number_to_ascii_formatter #(
  parameter int CHARS_PER_ROW = ntaf_pkg::NTAF_CHARS_PER_ROW,
  parameter int MAX_DIGITS    = ntaf_pkg::NTAF_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_number,
  input  logic [5:0]  in_length,
  input  logic [2:0]  in_start_line,
  input  logic [6:0]  in_start_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_glyph_code,
  output logic [2:0]  out_text_line,
  output logic [5:0]  out_text_column,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import ntaf_pkg::*;

  ntaf_cmd_t cmd;
  ntaf_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  ntaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  ntaf_datapath #(
    .CHARS_PER_ROW (CHARS_PER_ROW),
    .MAX_DIGITS    (MAX_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_func         (in_func),
    .in_number       (in_number),
    .in_length       (in_length),
    .in_start_line   (in_start_line),
    .in_start_column (in_start_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph_code  (out_glyph_code),
    .out_text_line   (out_text_line),
    .out_text_column (out_text_column),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data)
  );

endmodule

>>> verif/ntaf_glyph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntaf_glyph_checker
// Watches the number, glyph and config channels of the formatter, works out
// the characters each accepted number should produce and compares every
// glyph beat against the oldest outstanding one.
// ----------------------------------------------------------------------------
module ntaf_glyph_checker #(
  parameter int CHARS_PER_ROW = ntaf_pkg::NTAF_CHARS_PER_ROW,
  parameter int MAX_DIGITS    = ntaf_pkg::NTAF_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_number,
  input  logic [5:0]  in_length,
  input  logic [2:0]  in_start_line,
  input  logic [6:0]  in_start_column,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  out_glyph_code,
  input  logic [2:0]  out_text_line,
  input  logic [5:0]  out_text_column,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          mismatches,
  output int          due_count
);
  import ntaf_pkg::*;

  typedef struct packed {
    logic [6:0] glyph;
    logic [2:0] line;
    logic [5:0] col;
    logic       last;
  } glyph_beat_t;

  glyph_beat_t glyphs_due[$];
  logic [3:0]  lines_reg = NTAF_DISPLAY_LINES_RESET;
  int          errors = 0;

  initial begin
    mismatches = 0;
    due_count  = 0;
  end

  // queue one character at its wrapped screen position
  function automatic void push_glyph(input logic [6:0] g, input logic [2:0] line0,
                                     input int col, input logic last);
    int rows;
    int ln;
    glyph_beat_t b;
    rows = (lines_reg == 4'd0) ? 1 : ((lines_reg > 4'd8) ? 8 : int'(lines_reg));
    ln = int'(line0) + col / CHARS_PER_ROW;
    ln = ln % rows;
    b.glyph = g;
    b.line  = 3'(ln);
    b.col   = 6'(col % CHARS_PER_ROW);
    b.last  = last;
    glyphs_due.push_back(b);
  endfunction

  // expand one number into its characters
  function automatic void format_number(input logic [2:0] func, input logic [31:0] number,
                                        input logic [5:0] length, input logic [2:0] line,
                                        input logic [6:0] column);
    int          len;
    int          col;
    int          p;
    int          k;
    int unsigned base;
    int unsigned mag;
    int unsigned val;
    int unsigned d;
    logic        blank;
    logic [6:0]  g;
    len   = (int'(length) > MAX_DIGITS) ? MAX_DIGITS : int'(length);
    col   = int'(column);
    base  = (func == FUNC_HEX) ? 16 : 10;
    mag   = number;
    blank = (func == FUNC_BLANK);
    if (func == FUNC_BIN) begin
      // fixed-width bit string, nothing at all for length zero
      for (p = len; p > 0; p--) begin
        push_glyph(CH_ZERO + 7'(number[p-1]), line, col + len - p, p == 1);
      end
    end else if (func == FUNC_BLANK && number == 32'd0) begin
      // zero in blanked mode: lone '0' in the rightmost slot
      len = (len == 0) ? 1 : len;
      push_glyph(CH_ZERO, line, col + len - 1, 1'b1);
    end else if (func <= FUNC_HEX) begin
      if (func == FUNC_SDEC) begin
        if (number[31]) begin
          push_glyph(CH_MINUS, line, col, 1'b0);
          mag = 32'd0 - number;
        end else if (number != 32'd0) begin
          push_glyph(CH_PLUS, line, col, 1'b0);
        end
        col++;
      end
      if (len == 0) begin
        len = 1;
        val = mag;
        while (val >= base) begin
          val = val / base;
          len++;
        end
      end
      for (p = len; p > 0; p--) begin
        // digits past the 32-bit range fall out as zero
        val = mag;
        for (k = 0; k < p - 1 && val != 0; k++) val = val / base;
        d = val % base;
        g = (d < 10) ? CH_ZERO + 7'(d) : CH_A + 7'(d - 10);
        if (blank) begin
          if (d == 0) g = CH_SPACE;
          else blank = 1'b0;
        end
        push_glyph(g, line, col + len - p, p == 1);
      end
    end
  endfunction

  function automatic void note_mismatch(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endfunction

  // output beats are checked before the same edge's input beat is predicted
  always @(posedge clk) begin
    glyph_beat_t want;
    if (!rst_n) begin
      lines_reg = NTAF_DISPLAY_LINES_RESET;
      glyphs_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (glyphs_due.size() == 0) begin
          $display("%0t: unexpected glyph beat, expected none, actual %h line %0d col %0d last %0b",
                   $time, out_glyph_code, out_text_line, out_text_column, out_last);
          errors++;
        end else begin
          want = glyphs_due.pop_front();
          if (out_glyph_code !== want.glyph)
            note_mismatch("glyph_code", want.glyph, out_glyph_code);
          if (out_text_line !== want.line)
            note_mismatch("text_line", want.line, out_text_line);
          if (out_text_column !== want.col)
            note_mismatch("text_column", want.col, out_text_column);
          if (out_last !== want.last)
            note_mismatch("last", want.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) lines_reg = cfg_data;
      if (in_valid && !in_stall)
        format_number(in_func, in_number, in_length, in_start_line, in_start_column);
    end
    mismatches <= errors;
    due_count  <= glyphs_due.size();
  end

endmodule

>>> verif/number_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_tb
// Drives numbers in every format through the formatter with random gaps and
// back-pressure, changes the line count between phases and leaves checking
// of each glyph beat to ntaf_glyph_checker.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_tb;
  import ntaf_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 64;
  localparam int DRAIN_LIMIT  = 50000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [31:0] in_number;
  logic [5:0]  in_length;
  logic [2:0]  in_start_line;
  logic [6:0]  in_start_column;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_glyph_code;
  logic [2:0]  out_text_line;
  logic [5:0]  out_text_column;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  int          mismatches;
  int          due_count;

  logic        tx_gaps;
  logic        rx_gaps;
  logic        hold_req;

  number_to_ascii_formatter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_number       (in_number),
    .in_length       (in_length),
    .in_start_line   (in_start_line),
    .in_start_column (in_start_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph_code  (out_glyph_code),
    .out_text_line   (out_text_line),
    .out_text_column (out_text_column),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  ntaf_glyph_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_number       (in_number),
    .in_length       (in_length),
    .in_start_line   (in_start_line),
    .in_start_column (in_start_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph_code  (out_glyph_code),
    .out_text_line   (out_text_line),
    .out_text_column (out_text_column),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .due_count       (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // offer one number and hold it until accepted
  task automatic send_number(input logic [2:0] f, input logic [31:0] num,
                             input logic [5:0] len, input logic [2:0] ln,
                             input logic [6:0] colm);
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_func         = f;
    in_number       = num;
    in_length       = len;
    in_start_line   = ln;
    in_start_column = colm;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [2:0]  f;
    logic [31:0] num;
    logic [5:0]  len;
    int unsigned r;
    r = $urandom_range(0, 19);
    f = (r < 18) ? 3'(r % 5) : 3'($urandom_range(5, 7));
    case ($urandom_range(0, 5))
      0:       num = 32'd0;
      1:       num = $urandom_range(0, 999);
      2:       num = 32'd1 << $urandom_range(0, 31);
      3:       num = 32'h8000_0000 ^ $urandom_range(0, 15);
      default: num = $urandom;
    endcase
    r = $urandom_range(0, 9);
    if (r < 3)      len = 6'd0;
    else if (r < 8) len = 6'($urandom_range(1, 12));
    else if (r < 9) len = 6'($urandom_range(13, 32));
    else            len = 6'($urandom_range(33, 63));
    send_number(f, num, len, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
  endtask

  // drop valid, wait for every outstanding beat, then let the block settle
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (due_count == 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_lines(input logic [3:0] v);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [3:0] phase_lines[5];
    int         waited;
    phase_lines = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_UDEC;
    in_number       = 32'd0;
    in_length       = 6'd0;
    in_start_line   = 3'd0;
    in_start_column = 7'd0;
    cfg_valid       = 1'b0;
    cfg_data        = 4'd0;
    tx_gaps         = 1'b1;
    rx_gaps         = 1'b1;
    hold_req        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners with the reset line count
    send_number(FUNC_UDEC,  32'd0,          6'd0,  3'd0, 7'd0);
    send_number(FUNC_UDEC,  32'hFFFF_FFFF,  6'd0,  3'd7, 7'd127);
    send_number(FUNC_UDEC,  32'd12345,      6'd8,  3'd1, 7'd10);
    send_number(FUNC_UDEC,  32'hFFFF_FFFF,  6'd63, 3'd2, 7'd5);
    send_number(FUNC_BLANK, 32'd0,          6'd0,  3'd3, 7'd15);
    send_number(FUNC_BLANK, 32'd0,          6'd5,  3'd0, 7'd62);
    send_number(FUNC_BLANK, 32'd1000,       6'd10, 3'd4, 7'd0);
    send_number(FUNC_BLANK, 32'hFFFF_FFFF,  6'd40, 3'd5, 7'd100);
    send_number(FUNC_SDEC,  32'd0,          6'd0,  3'd6, 7'd14);
    send_number(FUNC_SDEC,  32'd123,        6'd0,  3'd0, 7'd15);
    send_number(FUNC_SDEC,  32'hFFFF_FFFF,  6'd0,  3'd1, 7'd31);
    send_number(FUNC_SDEC,  32'h8000_0000,  6'd0,  3'd7, 7'd120);
    send_number(FUNC_SDEC,  32'h7FFF_FFFF,  6'd12, 3'd2, 7'd3);
    send_number(FUNC_SDEC,  32'h8000_0000,  6'd32, 3'd3, 7'd127);
    send_number(FUNC_HEX,   32'hDEAD_BEEF,  6'd0,  3'd4, 7'd8);
    send_number(FUNC_HEX,   32'd0,          6'd0,  3'd5, 7'd0);
    send_number(FUNC_HEX,   32'h00AB_CDEF,  6'd32, 3'd6, 7'd64);
    send_number(FUNC_BIN,   32'hA5A5_A5A5,  6'd32, 3'd7, 7'd1);
    send_number(FUNC_BIN,   32'd5,          6'd0,  3'd0, 7'd0);
    send_number(FUNC_BIN,   32'd1,          6'd1,  3'd1, 7'd127);
    send_number(FUNC_BIN,   32'hFFFF_FFFF,  6'd63, 3'd2, 7'd33);
    send_number(3'd5,       32'd77,         6'd4,  3'd3, 7'd2);
    send_number(3'd6,       32'hFFFF_FFFF,  6'd0,  3'd4, 7'd9);
    send_number(3'd7,       32'd1,          6'd63, 3'd5, 7'd127);
    send_number(FUNC_UDEC,  32'd42,         6'd0,  3'd7, 7'd79);

    // long receiver hold while numbers keep coming, so the block backs up
    hold_req = 1'b1;
    repeat (12) send_random();
    settle();

    // random phases across line counts, one phase without each kind of gap
    for (int ph = 0; ph < 5; ph++) begin
      write_lines(phase_lines[ph]);
      tx_gaps = (ph != 2);
      rx_gaps = (ph != 1);
      repeat (70) send_random();
    end

    // closing stretch at full rate
    write_lines(4'($urandom_range(1, 8)));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (50) send_random();

    @(negedge clk);
    in_valid = 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && due_count != 0; waited++) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (due_count != 0)
      $display("%0t: %0d glyph beats never arrived", $time, due_count);
    if (mismatches == 0 && due_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
